// ===== rtl/tprs_pkg.sv =====
// Package for the timer prescale/reload split block.
// Shared widths, constants and the divider control struct.
// No dependencies.
package tprs_pkg;

  localparam int DIV_W = 32;
  localparam int CNT_W = 24;
  localparam int STEP_W = 6;

  localparam int PRESCALE_LIMIT_DEF = 256;
  localparam int RELOAD_MAX_DEF = 65535;

  localparam logic [DIV_W-1:0] US_PER_SEC = 32'd1000000;
  localparam logic [DIV_W-1:0] COUNT_LIMIT = 32'd16777215;
  localparam logic [DIV_W-1:0] BUS_CLOCK_RESET = 32'd8000000;

  typedef struct packed {
    logic start;
    logic narrow;
  } div_ctrl_t;

endpackage

// ===== rtl/tprs_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Narrow mode runs CNT_W steps on a CNT_W-bit dividend. Uses tprs_pkg.
module tprs_div
  import tprs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  logic              busy;
  logic [STEP_W-1:0] left;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    part;
  logic [DIV_W+1:0]  diff;
  logic              ge;
  logic [DIV_W-1:0]  rem_next;
  logic [DIV_W-1:0]  quo_next;

  always_comb begin
    part = {rem, quo[DIV_W-1]};
    diff = {1'b0, part} - {2'b00, dvs};
    ge = ~diff[DIV_W+1];
    rem_next = ge ? diff[DIV_W-1:0] : part[DIV_W-1:0];
    quo_next = {quo[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        left <= ctrl.narrow ? STEP_W'(CNT_W) : STEP_W'(DIV_W);
      end else if (busy) begin
        left <= left - STEP_W'(1);
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= ctrl.narrow ? {dividend[CNT_W-1:0], {(DIV_W-CNT_W){1'b0}}} : dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;
  assign remainder = rem;

endmodule

// ===== rtl/tprs_seq.sv =====
// Sequencer: interval to count, then factor search on the shared divider.
// Depends on tprs_pkg; drives one tprs_div.
module tprs_seq
  import tprs_pkg::*;
#(
  parameter int PRESCALE_LIMIT = PRESCALE_LIMIT_DEF,
  parameter int RELOAD_MAX = RELOAD_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [DIV_W-1:0] bus_clock_hz,
  input  logic             start,
  input  logic [DIV_W-1:0] interval,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_take,
  output logic             res_error,
  output logic [7:0]       res_prescale,
  output logic [15:0]      res_reload,
  output div_ctrl_t        div_ctrl,
  output logic [DIV_W-1:0] div_a,
  output logic [DIV_W-1:0] div_b,
  input  logic             div_done,
  input  logic [DIV_W-1:0] div_q,
  input  logic [DIV_W-1:0] div_r
);

  localparam int FAC_W = $clog2(PRESCALE_LIMIT);
  localparam logic [FAC_W-1:0] FAC_LAST = FAC_W'(PRESCALE_LIMIT - 1);
  localparam logic [DIV_W-1:0] RELOAD_TOP = DIV_W'(RELOAD_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INNER = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_FAC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state;
  logic [FAC_W-1:0] fac;
  logic [FAC_W-1:0] fac_m1;
  logic [CNT_W-1:0] count;

  assign fac_m1 = fac - FAC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_ctrl <= '0;
    end else begin
      div_ctrl <= '0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (interval == '0) begin
              state <= S_DONE;
            end else begin
              div_ctrl.start <= 1'b1;
              state <= S_INNER;
            end
          end
        end
        S_INNER: begin
          if (div_done) begin
            if (div_q == '0) begin
              state <= S_DONE;
            end else begin
              div_ctrl.start <= 1'b1;
              state <= S_COUNT;
            end
          end
        end
        S_COUNT: begin
          if (div_done) begin
            if (div_q > COUNT_LIMIT) begin
              state <= S_DONE;
            end else begin
              div_ctrl.start <= 1'b1;
              div_ctrl.narrow <= 1'b1;
              state <= S_FAC;
            end
          end
        end
        S_FAC: begin
          if (div_done) begin
            if ((div_r == '0 && div_q <= RELOAD_TOP) || fac == FAC_LAST) begin
              state <= S_DONE;
            end else begin
              div_ctrl.start <= 1'b1;
              div_ctrl.narrow <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_error <= 1'b1;
        res_prescale <= '0;
        res_reload <= '0;
        div_a <= US_PER_SEC;
        div_b <= interval;
        fac <= FAC_W'(1);
      end
      S_INNER: begin
        div_a <= bus_clock_hz;
        div_b <= div_q;
      end
      S_COUNT: begin
        count <= div_q[CNT_W-1:0];
        div_a <= DIV_W'(div_q[CNT_W-1:0]);
        div_b <= DIV_W'(1);
      end
      S_FAC: begin
        if (div_done) begin
          if (div_r == '0 && div_q <= RELOAD_TOP) begin
            res_error <= 1'b0;
            res_prescale <= 8'(fac_m1);
            res_reload <= div_q[15:0] - 16'd1;
          end else begin
            fac <= fac + FAC_W'(1);
            div_a <= DIV_W'(count);
            div_b <= DIV_W'(fac + FAC_W'(1));
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign idle = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

endmodule

// ===== rtl/timer_prescale_reload_split_unit.sv =====
// Timer prescale/reload split: interval in us to prescale and reload.
// Top level; uses tprs_pkg, tprs_seq and tprs_div.
//
// Usage: write bus_clock_hz through cfg_we/cfg_wdata (reset 8000000) while
// idle. Present interval_us with in_valid; the item is taken on a cycle with
// in_valid high and in_stall low. One result item follows on out_valid with
// error, prescale_value and reload_value; it is taken when out_stall is low.
// Steps: all work runs on one bit-serial divider: 1000000/interval, then
// bus/divisor, then one division of the count per trial factor. A zero
// interval answers without the divider; an overlong one stops after the
// first division. One item is in work at a time; in_stall stays high
// from acceptance until the result moves into the output register. A
// stalled result holds in the output register, and the next item may be
// accepted and computed meanwhile; its result waits in the sequencer
// until the output register frees up.
// Reset clears the sequencer, divider and output valid, and reloads the
// bus clock register.
module timer_prescale_reload_split_unit
  import tprs_pkg::*;
#(
  parameter int PRESCALE_LIMIT = PRESCALE_LIMIT_DEF,
  parameter int RELOAD_MAX = RELOAD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] interval_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        error,
  output logic [7:0]  prescale_value,
  output logic [15:0] reload_value
);

  logic [DIV_W-1:0] bus_clock_hz;
  logic             idle;
  logic             res_valid;
  logic             res_take;
  logic             res_error;
  logic [7:0]       res_prescale;
  logic [15:0]      res_reload;
  div_ctrl_t        div_ctrl;
  logic [DIV_W-1:0] div_a;
  logic [DIV_W-1:0] div_b;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] div_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_clock_hz <= BUS_CLOCK_RESET;
    end else if (cfg_we) begin
      bus_clock_hz <= cfg_wdata;
    end
  end

  assign in_stall = ~idle;

  tprs_seq #(
    .PRESCALE_LIMIT(PRESCALE_LIMIT),
    .RELOAD_MAX(RELOAD_MAX)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .bus_clock_hz(bus_clock_hz),
    .start(in_valid & idle),
    .interval(interval_us),
    .idle(idle),
    .res_valid(res_valid),
    .res_take(res_take),
    .res_error(res_error),
    .res_prescale(res_prescale),
    .res_reload(res_reload),
    .div_ctrl(div_ctrl),
    .div_a(div_a),
    .div_b(div_b),
    .div_done(div_done),
    .div_q(div_q),
    .div_r(div_r)
  );

  tprs_div u_div (
    .clk(clk),
    .rst(rst),
    .ctrl(div_ctrl),
    .dividend(div_a),
    .divisor(div_b),
    .done(div_done),
    .quotient(div_q),
    .remainder(div_r)
  );

  assign res_take = res_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      error <= res_error;
      prescale_value <= res_prescale;
      reload_value <= res_reload;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> prescale_value == 8'd0 && reload_value == 16'd0)
    else $error("error result carries nonzero fields");

  a_pre_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> 32'(prescale_value) <= 32'(PRESCALE_LIMIT - 2))
    else $error("prescale beyond factor range");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_done |-> !idle && !res_valid)
    else $error("divider finished with no step waiting");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    res_take |=> idle)
    else $error("sequencer not idle after handing off result");

endmodule
